/* src/fpba_pkg.sv */
// fpba_pkg: shared types and codes for the fit-policy block allocator
// no dependencies; imported by the controller, datapath and top level
package fpba_pkg;

  localparam int ACT_W   = 2;
  localparam int IDX_W   = 4;
  localparam int AMT_W   = 16;
  localparam int CFG_IW  = 1;
  localparam int CFG_DW  = 5;
  localparam int MODE_W  = 2;
  localparam int BIU_W   = 5;

  typedef logic [ACT_W-1:0]  action_t;
  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [CFG_IW-1:0] reg_idx_t;

  localparam action_t ACT_LOAD  = 2'd0;
  localparam action_t ACT_ALLOC = 2'd1;
  localparam action_t ACT_READ  = 2'd2;

  localparam mode_t MODE_FIRST = 2'd0;
  localparam mode_t MODE_BEST  = 2'd1;
  localparam mode_t MODE_WORST = 2'd2;

  localparam reg_idx_t REG_FIT_MODE      = 1'b0;
  localparam reg_idx_t REG_BLOCKS_IN_USE = 1'b1;

  localparam logic [BIU_W-1:0]  BIU_RESET  = 5'd16;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic access;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic scan_done;
  } sts_t;

endpackage

/* src/fpba_ctrl.sv */
// fpba_ctrl: sequencing state machine for the block allocator
// depends on fpba_pkg; drives commands into fpba_dpath
module fpba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  fpba_pkg::action_t in_action,
  output logic              in_ready,
  input  fpba_pkg::sts_t    sts,
  output fpba_pkg::cmd_t    cmd
);
  import fpba_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action inside {ACT_LOAD, ACT_READ}) begin
            state_nxt = S_ACCESS;
          end else if (in_action == ACT_ALLOC) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_ACCESS: begin
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_ACCESS: begin
        cmd.access = 1'b1;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_DONE: begin
        cmd.finish = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* src/fpba_dpath.sv */
// fpba_dpath: capacity table, fit search, config registers and result register
// depends on fpba_pkg; commanded by fpba_ctrl
module fpba_dpath #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  fpba_pkg::reg_idx_t           cfg_index,
  input  logic [fpba_pkg::CFG_DW-1:0]  cfg_data,
  input  fpba_pkg::action_t            in_action,
  input  logic [fpba_pkg::IDX_W-1:0]   in_block_index,
  input  logic [fpba_pkg::AMT_W-1:0]   in_amount,
  input  logic                         out_ready,
  input  fpba_pkg::cmd_t               cmd,
  output fpba_pkg::sts_t               sts,
  output logic                         out_valid,
  output logic                         out_granted,
  output logic [fpba_pkg::IDX_W-1:0]   out_chosen_block,
  output logic [fpba_pkg::AMT_W-1:0]   out_remaining
);
  import fpba_pkg::*;

  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CW = $clog2(NUM_BLOCKS + 1);

  // config registers
  mode_t             fit_mode_r;
  logic [BIU_W-1:0]  biu_r;

  // captured item
  action_t               act_r;
  logic [IDX_W-1:0]      idx_r;
  logic                  in_range_r;
  logic [SIZE_WIDTH-1:0] amt_r;

  // capacity table
  logic [SIZE_WIDTH-1:0] mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] vld_r;
  logic [SIZE_WIDTH-1:0] rd_q_r;
  logic                  rd_vld_r;
  logic [AW-1:0]         rd_addr;
  logic [SIZE_WIDTH-1:0] rd_val;
  logic                  we;
  logic [AW-1:0]         wa;
  logic [SIZE_WIDTH-1:0] wd;

  // search
  logic [CW-1:0]         limit;
  logic [CW-1:0]         scan_idx_r;
  logic                  issue;
  logic                  cmp_vld_r;
  logic [AW-1:0]         cmp_idx_r;
  logic                  found_r;
  logic [AW-1:0]         pick_r;
  logic [SIZE_WIDTH-1:0] best_r;
  logic                  take;
  logic [SIZE_WIDTH-1:0] alloc_rem;

  // result register
  logic                  out_valid_r;
  logic                  out_granted_r;
  logic [IDX_W-1:0]      out_chosen_r;
  logic [AMT_W-1:0]      out_rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r <= MODE_RESET;
      biu_r      <= BIU_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_FIT_MODE) begin
        fit_mode_r <= cfg_data[MODE_W-1:0];
      end else if (cfg_index == REG_BLOCKS_IN_USE) begin
        biu_r <= cfg_data[BIU_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r      <= in_action;
      idx_r      <= in_block_index;
      in_range_r <= (32'(in_block_index) < 32'(NUM_BLOCKS));
      amt_r      <= SIZE_WIDTH'(in_amount);
    end
  end

  assign limit = (32'(biu_r) >= 32'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : CW'(biu_r);
  assign issue = cmd.scan && (scan_idx_r < limit);

  assign rd_addr = cmd.scan ? AW'(scan_idx_r) : AW'(idx_r);

  always_ff @(posedge clk) begin
    rd_q_r   <= mem[rd_addr];
    rd_vld_r <= vld_r[rd_addr];
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[wa] <= 1'b1;
    end
  end

  assign rd_val    = rd_vld_r ? rd_q_r : '0;
  assign alloc_rem = best_r - amt_r;

  assign we = (cmd.access && act_r == ACT_LOAD && in_range_r)
           || (cmd.finish && act_r == ACT_ALLOC && found_r);
  assign wa = cmd.finish ? pick_r : AW'(idx_r);
  assign wd = cmd.finish ? alloc_rem : amt_r;

  assign take = cmp_vld_r && (rd_val >= amt_r)
             && (!found_r
                 || (fit_mode_r == MODE_BEST  && rd_val < best_r)
                 || (fit_mode_r == MODE_WORST && rd_val > best_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
      found_r    <= 1'b0;
    end else if (cmd.capture) begin
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      cmp_vld_r <= issue;
      if (issue) begin
        scan_idx_r <= scan_idx_r + CW'(1);
      end
      if (take) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= AW'(scan_idx_r);
    if (take) begin
      pick_r <= cmp_idx_r;
      best_r <= rd_val;
    end
  end

  assign sts.scan_done = (scan_idx_r >= limit) && !cmp_vld_r;
  assign sts.out_busy  = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      case (act_r)
        ACT_LOAD: begin
          out_granted_r <= in_range_r;
          out_chosen_r  <= idx_r;
          out_rem_r     <= in_range_r ? AMT_W'(amt_r) : '0;
        end
        ACT_READ: begin
          out_granted_r <= in_range_r;
          out_chosen_r  <= idx_r;
          out_rem_r     <= in_range_r ? AMT_W'(rd_val) : '0;
        end
        ACT_ALLOC: begin
          out_granted_r <= found_r;
          out_chosen_r  <= found_r ? IDX_W'(pick_r) : '0;
          out_rem_r     <= found_r ? AMT_W'(alloc_rem) : '0;
        end
        default: begin
          out_granted_r <= 1'b0;
          out_chosen_r  <= '0;
          out_rem_r     <= '0;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted      = out_granted_r;
  assign out_chosen_block = out_chosen_r;
  assign out_remaining    = out_rem_r;

endmodule

/* src/fit_policy_block_allocator.sv */
// fit_policy_block_allocator: top level of the first/best/worst fit block allocator
// depends on fpba_pkg, fpba_ctrl and fpba_dpath
//
// Keeps a table of remaining capacity for NUM_BLOCKS blocks and serves one item at a
// time. After an item is accepted, a load or read passes through an access state, an unused
// action goes straight to the done state, and an allocate first scans the lowest
// min(blocks_in_use, NUM_BLOCKS) blocks of the single-read-port capacity table, one
// block per cycle, before its result is loaded. The table comes out of reset as all
// zeros with no clearing pass. The result sits in an output register; the next item is
// taken once the result is loaded there, and a result still waiting there holds back the
// next one. Config writes are always accepted and must only be issued while the block
// is idle.
module fit_policy_block_allocator #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  fpba_pkg::reg_idx_t           cfg_index,
  input  logic [fpba_pkg::CFG_DW-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  fpba_pkg::action_t            in_action,
  input  logic [fpba_pkg::IDX_W-1:0]   in_block_index,
  input  logic [fpba_pkg::AMT_W-1:0]   in_amount,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_granted,
  output logic [fpba_pkg::IDX_W-1:0]   out_chosen_block,
  output logic [fpba_pkg::AMT_W-1:0]   out_remaining
);
  import fpba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  fpba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpba_dpath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_action        (in_action),
    .in_block_index   (in_block_index),
    .in_amount        (in_amount),
    .out_ready        (out_ready),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_granted      (out_granted),
    .out_chosen_block (out_chosen_block),
    .out_remaining    (out_remaining)
  );

endmodule

/* src/fpba_checker.sv */
// fpba_sva: port-level checks for the block allocator
// depends on fpba_pkg; bound to fit_policy_block_allocator
module fpba_sva (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_granted,
  input logic [fpba_pkg::IDX_W-1:0]  out_chosen_block,
  input logic [fpba_pkg::AMT_W-1:0]  out_remaining
);
  import fpba_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_granted)
      && $stable(out_chosen_block) && $stable(out_remaining))
    else $error("result beat changed while stalled");

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // refused work reports no capacity
  a_deny_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_remaining == '0)
    else $error("denied result carries capacity");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fit_policy_block_allocator fpba_sva u_fpba_sva (.*);

/* verif/fpba_checker.sv */
// fpba_checker: watches the config, item and result channels of the fit-policy
// block allocator, keeps its own copy of the capacity table and checks every result
// depends on fpba_pkg
module fpba_checker #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  fpba_pkg::reg_idx_t          cfg_index,
  input  logic [fpba_pkg::CFG_DW-1:0] cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  fpba_pkg::action_t           in_action,
  input  logic [fpba_pkg::IDX_W-1:0]  in_block_index,
  input  logic [fpba_pkg::AMT_W-1:0]  in_amount,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        out_granted,
  input  logic [fpba_pkg::IDX_W-1:0]  out_chosen_block,
  input  logic [fpba_pkg::AMT_W-1:0]  out_remaining,
  output int                          errors,
  output int                          pending,
  output int                          results_checked,
  output int                          granted_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import fpba_pkg::*;

  typedef struct packed {
    logic             granted;
    logic [IDX_W-1:0] blk;
    logic [AMT_W-1:0] rem;
  } grant_t;

  logic [SIZE_WIDTH-1:0] capacity [NUM_BLOCKS];
  mode_t                 fit_mode;
  logic [BIU_W-1:0]      blocks_in_use;
  grant_t                expected_grants [$];
  int                    err_count = 0;
  int                    checked = 0;
  int                    grants = 0;

  function automatic grant_t serve_item(input action_t act, input logic [IDX_W-1:0] idx,
                                        input logic [AMT_W-1:0] amount);
    grant_t                r;
    logic [SIZE_WIDTH-1:0] req;
    int                    lim;
    int                    pick;
    bit                    found;
    r = '0;
    req = SIZE_WIDTH'(amount);
    pick = 0;
    found = 1'b0;
    case (act)
      ACT_LOAD, ACT_READ: begin
        r.blk = idx;
        if (idx < NUM_BLOCKS) begin
          if (act == ACT_LOAD) capacity[idx] = req;
          r.granted = 1'b1;
          r.rem = AMT_W'(capacity[idx]);
        end
      end
      ACT_ALLOC: begin
        lim = (blocks_in_use > NUM_BLOCKS) ? NUM_BLOCKS : int'(blocks_in_use);
        for (int j = 0; j < lim; j++) begin
          if (capacity[j] >= req) begin
            if (!found) begin
              pick = j;
              found = 1'b1;
              if (fit_mode != MODE_BEST && fit_mode != MODE_WORST) break;
            end else if (fit_mode == MODE_BEST && capacity[j] < capacity[pick]) begin
              pick = j;
            end else if (fit_mode == MODE_WORST && capacity[j] > capacity[pick]) begin
              pick = j;
            end
          end
        end
        if (found) begin
          capacity[pick] = capacity[pick] - req;
          r.granted = 1'b1;
          r.blk = IDX_W'(pick);
          r.rem = AMT_W'(capacity[pick]);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag(input string what, input logic [AMT_W-1:0] want_v,
                      input logic [AMT_W-1:0] got_v);
    err_count++;
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_BLOCKS; i++) capacity[i] = '0;
      fit_mode = MODE_RESET;
      blocks_in_use = BIU_RESET;
      expected_grants.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FIT_MODE:      fit_mode = cfg_data[MODE_W-1:0];
          REG_BLOCKS_IN_USE: blocks_in_use = cfg_data[BIU_W-1:0];
          default: ;
        endcase
      end
      // result beat is checked before a new item beat is queued
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none actual %0b/%0h/%0h", $time,
                   out_granted, out_chosen_block, out_remaining);
        end else begin
          want = expected_grants.pop_front();
          checked++;
          if (want.granted) grants++;
          if (out_granted !== want.granted)
            flag("granted", AMT_W'(want.granted), AMT_W'(out_granted));
          if (out_chosen_block !== want.blk)
            flag("chosen_block", AMT_W'(want.blk), AMT_W'(out_chosen_block));
          if (out_remaining !== want.rem) flag("remaining", want.rem, out_remaining);
        end
      end
      if (in_valid && in_ready)
        expected_grants.push_back(serve_item(in_action, in_block_index, in_amount));
    end
    errors <= err_count;
    pending <= expected_grants.size();
    results_checked <= checked;
    granted_count <= grants;
  end

endmodule

/* verif/fit_policy_block_allocator_test.sv */
// fit_policy_block_allocator_test: stimulus and verdict for the fit-policy block allocator
// depends on fpba_pkg, fit_policy_block_allocator and fpba_checker
module fit_policy_block_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fpba_pkg::*;

  localparam int NB = 16;
  localparam int SW = 16;
  localparam action_t ACT_UNUSED = 2'd3;
  localparam mode_t MODE_SPARE = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  reg_idx_t          cfg_index = REG_FIT_MODE;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  action_t           in_action = ACT_LOAD;
  logic [IDX_W-1:0]  in_block_index = '0;
  logic [AMT_W-1:0]  in_amount = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_granted;
  logic [IDX_W-1:0]  out_chosen_block;
  logic [AMT_W-1:0]  out_remaining;

  int errors;
  int pending;
  int results_checked;
  int granted_count;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int cfg_settings = 0;

  fit_policy_block_allocator #(.NUM_BLOCKS(NB), .SIZE_WIDTH(SW)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_block_index   (in_block_index),
    .in_amount        (in_amount),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted      (out_granted),
    .out_chosen_block (out_chosen_block),
    .out_remaining    (out_remaining)
  );

  fpba_checker #(.NUM_BLOCKS(NB), .SIZE_WIDTH(SW)) u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_block_index   (in_block_index),
    .in_amount        (in_amount),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted      (out_granted),
    .out_chosen_block (out_chosen_block),
    .out_remaining    (out_remaining),
    .errors           (errors),
    .pending          (pending),
    .results_checked  (results_checked),
    .granted_count    (granted_count)
  );

  always #10 clk = ~clk;

  always @(posedge clk) out_ready <= ($urandom_range(99, 0) >= stall_pct);

  initial begin
    #10_000_000;
    $display("timed out waiting on the allocator");
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_item(input action_t act, input logic [IDX_W-1:0] idx,
                           input logic [AMT_W-1:0] amt);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_block_index <= idx;
    in_amount <= amt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input mode_t m, input logic [CFG_DW-1:0] n);
    drain;
    repeat (4) @(posedge clk);
    write_reg(REG_FIT_MODE, CFG_DW'(m));
    write_reg(REG_BLOCKS_IN_USE, n);
    cfg_valid <= 1'b0;
    cfg_settings++;
  endtask

  task automatic random_config;
    logic [CFG_DW-1:0] n;
    case ($urandom_range(9, 0))
      0:       n = 5'd0;
      1:       n = 5'd31;
      2:       n = 5'd17;
      3:       n = 5'd1;
      default: n = CFG_DW'($urandom_range(16, 1));
    endcase
    set_config(mode_t'($urandom_range(3, 0)), n);
  endtask

  task automatic random_item;
    int               pick;
    logic [IDX_W-1:0] idx;
    logic [AMT_W-1:0] amt;
    pick = $urandom_range(99, 0);
    idx = IDX_W'($urandom_range(15, 0));
    amt = AMT_W'($urandom);
    // small multiples make ties between blocks likely
    if (pick < 25) begin
      if ($urandom_range(3, 0) != 0) amt = AMT_W'($urandom_range(16, 0) * 64);
      send_item(ACT_LOAD, idx, amt);
    end else if (pick < 80) begin
      if ($urandom_range(9, 0) != 0) amt = AMT_W'($urandom_range(300, 0));
      send_item(ACT_ALLOC, idx, amt);
    end else if (pick < 95) begin
      send_item(ACT_READ, idx, amt);
    end else begin
      send_item(ACT_UNUSED, idx, amt);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset table, zero request, loads, full-width request, unused action
    send_item(ACT_READ, 4'd0, 16'h0000);
    send_item(ACT_ALLOC, 4'd7, 16'h0000);
    send_item(ACT_ALLOC, 4'd0, 16'h0001);
    send_item(ACT_LOAD, 4'd15, 16'hFFFF);
    send_item(ACT_LOAD, 4'd0, 16'h0001);
    send_item(ACT_LOAD, 4'd5, 16'd100);
    send_item(ACT_LOAD, 4'd10, 16'd100);
    send_item(ACT_LOAD, 4'd3, 16'hAAAA);
    send_item(ACT_ALLOC, 4'd15, 16'hFFFF);
    send_item(ACT_UNUSED, 4'd9, 16'h5555);
    send_item(ACT_ALLOC, 4'd0, 16'd50);
    set_config(MODE_BEST, 5'd16);
    send_item(ACT_ALLOC, 4'd0, 16'd60);
    send_item(ACT_ALLOC, 4'd0, 16'd0);
    set_config(MODE_WORST, 5'd16);
    send_item(ACT_ALLOC, 4'd0, 16'd10);
    send_item(ACT_READ, 4'd3, 16'hFFFF);
    set_config(MODE_SPARE, 5'd0);
    send_item(ACT_ALLOC, 4'd0, 16'd0);
    set_config(MODE_SPARE, 5'd1);
    send_item(ACT_ALLOC, 4'd0, 16'd1);
    send_item(ACT_ALLOC, 4'd0, 16'd1);
    set_config(MODE_WORST, 5'd31);
    send_item(ACT_ALLOC, 4'd0, 16'd5);
    set_config(MODE_BEST, 5'd17);
    send_item(ACT_ALLOC, 4'd0, 16'd2);
    send_item(ACT_READ, 4'd10, 16'd0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 52; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 52; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        random_config;
        repeat (125) begin
          random_item;
          if ($urandom_range(99, 0) == 0) drain;
        end
      end
    end

    drain;
    repeat (30) @(posedge clk);
    $display("covered %0d items across %0d fit-mode/block-count settings",
             items_sent, cfg_settings);
    $display("%0d results checked, %0d of them granted", results_checked, granted_count);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
src/fpba_pkg.sv
src/fpba_ctrl.sv
src/fpba_dpath.sv
src/fit_policy_block_allocator.sv
src/fpba_checker.sv
verif/fpba_checker.sv
verif/fit_policy_block_allocator_test.sv
